// ===== sv/fqs_pkg.sv =====
`timescale 1ns / 1ps

package fqs_pkg;

  // Operation codes carried in the kind field of a request word.
  typedef enum logic [1:0] {
    KIND_ENQ    = 2'd0,
    KIND_DEQ    = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  // One request word.
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
  } req_word_t;

  // One response word.
  typedef struct packed {
    logic signed [31:0] taken_value;
    logic               found;
    logic               rejected;
    logic [4:0]         occupancy;
    logic signed [31:0] head_value;
    logic signed [31:0] tail_value;
    logic               now_empty;
  } rsp_word_t;

  // Controls broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic               shift;
    logic signed [31:0] wdata;
    logic signed [31:0] key;
  } cell_ctl_t;

  // Fan-in of one group in the registered match reduction.
  localparam int unsigned OR_GROUP = 32;

endpackage

// ===== sv/fifo_queue_with_search.sv =====
`timescale 1ns / 1ps
// Channel | Word       | Handshake
// req     | req_word_t | req_valid / req_stall, accepted when valid and not stall
// rsp     | rsp_word_t | rsp_valid / rsp_stall, accepted when valid and not stall
//
// Enqueue, dequeue and clear respond directly: the response word is registered at
// the edge that accepts the request. A search runs in steps: the key is
// registered, the row of cells compares in parallel, the match flags pass a
// two-level OR reduction with a registered first level, and the final flag loads the response.
// Reset clears the count and control; cell contents are undefined until written.
// A stalled response blocks new requests until the word is taken.

module fifo_queue_with_search
  import fqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_COMPARE = 4'b0010,
    ST_REDUCE  = 4'b0100,
    ST_REPORT  = 4'b1000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      cnt_next;
  logic signed [31:0] tail_val;
  logic signed [31:0] key;
  cell_ctl_t          ctl;
  logic               accept;
  logic               enq_ok;
  logic               deq_ok;
  logic               any_hit;
  logic               rsp_load;
  rsp_word_t          rsp_next;
  logic signed [31:0] cell_data [DEPTH];
  logic [DEPTH-1:0]   cell_match;

  // Request handshake.
  assign req_stall = (state != ST_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign enq_ok    = (req.kind == KIND_ENQ) && (cnt != CW'(DEPTH));
  assign deq_ok    = (req.kind == KIND_DEQ) && (cnt != '0);

  // Broadcast controls for the row.
  assign ctl.shift = accept && deq_ok;
  assign ctl.wdata = req.value;
  assign ctl.key   = key;

  // Row of cells; cell zero holds the oldest entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] nbr;
    if (i == DEPTH - 1) begin : g_last
      assign nbr = cell_data[i];
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end
    fqs_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .load     (accept && enq_ok && (cnt == CW'(i))),
      .live     (CW'(i) < cnt),
      .nbr_data (nbr),
      .data     (cell_data[i]),
      .match    (cell_match[i])
    );
  end

  fqs_or_tree #(.N(DEPTH)) u_tree (
    .clk  (clk),
    .bits (cell_match),
    .any  (any_hit)
  );

  // Count after the accepted operation.
  always_comb begin
    cnt_next = cnt;
    if (accept) begin
      case (req.kind)
        KIND_ENQ:    if (enq_ok) cnt_next = cnt + 1'b1;
        KIND_DEQ:    if (deq_ok) cnt_next = cnt - 1'b1;
        KIND_CLEAR:  cnt_next = '0;
        default:     cnt_next = cnt;
      endcase
    end
  end

  // Sequencer for the multi-cycle search.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (accept && req.kind == KIND_SEARCH) state_next = ST_COMPARE;
      ST_COMPARE: state_next = ST_REDUCE;
      ST_REDUCE:  state_next = ST_REPORT;
      ST_REPORT:  state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Response word for the operation that finishes this cycle.
  always_comb begin
    rsp_next             = '0;
    rsp_load             = 1'b0;
    rsp_next.occupancy   = 5'(cnt);
    rsp_next.now_empty   = (cnt == '0);
    rsp_next.head_value  = (cnt == '0) ? '0 : cell_data[0];
    rsp_next.tail_value  = (cnt == '0) ? '0 : tail_val;
    if (state == ST_REPORT) begin
      rsp_load       = 1'b1;
      rsp_next.found = any_hit;
    end else if (accept && req.kind != KIND_SEARCH) begin
      rsp_load           = 1'b1;
      rsp_next.occupancy = 5'(cnt_next);
      rsp_next.now_empty = (cnt_next == '0);
      case (req.kind)
        KIND_ENQ: begin
          rsp_next.rejected = !enq_ok;
          if (enq_ok) begin
            rsp_next.tail_value = req.value;
            rsp_next.head_value = (cnt == '0) ? req.value : cell_data[0];
          end
        end
        KIND_DEQ: begin
          rsp_next.rejected = !deq_ok;
          if (deq_ok) begin
            rsp_next.taken_value = cell_data[0];
            rsp_next.head_value  = (cnt_next == '0) ? '0 : cell_data[1];
            rsp_next.tail_value  = (cnt_next == '0) ? '0 : tail_val;
          end
        end
        default: begin
          rsp_next.head_value = '0;
          rsp_next.tail_value = '0;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
    if (accept && enq_ok) begin
      tail_val <= req.value;
    end
    if (accept && req.kind == KIND_SEARCH) begin
      key <= req.value;
    end
  end

  // The count never exceeds the depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("queue count above depth");

  // A search blocks requests until its response is loaded.
  a_search_blocks: assert property (@(posedge clk) disable iff (rst)
    (accept && req.kind == KIND_SEARCH) |=> (req_stall && state == ST_COMPARE))
    else $error("search did not enter compare");

  // The count only moves on an accepted request.
  a_cnt_moves: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(cnt))
    else $error("count changed without a request");

  // The output word is never overwritten while it waits.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> !rsp_load)
    else $error("response overwritten while stalled");

endmodule

// ===== sv/fqs_cell.sv =====
`timescale 1ns / 1ps

module fqs_cell
  import fqs_pkg::*;
(
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic               load,
  input  logic               live,
  input  logic signed [31:0] nbr_data,
  output logic signed [31:0] data,
  output logic               match
);

  // Hold, take the younger neighbor's entry on a dequeue, or take a new entry.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data <= nbr_data;
    end else if (load) begin
      data <= ctl.wdata;
    end
  end

  // Local compare against the search key; only occupied cells may hit.
  always_ff @(posedge clk) begin
    match <= live && (data == ctl.key);
  end

endmodule

// ===== sv/fqs_or_tree.sv =====
`timescale 1ns / 1ps

module fqs_or_tree
  import fqs_pkg::*;
#(
  parameter int N = 16
) (
  input  logic         clk,
  input  logic [N-1:0] bits,
  output logic         any
);

  localparam int NG = (N + OR_GROUP - 1) / OR_GROUP;

  logic [NG-1:0] grp;

  // First level: each group of cells is reduced and registered.
  for (genvar g = 0; g < NG; g++) begin : g_grp
    localparam int LO = g * OR_GROUP;
    localparam int HI = (LO + OR_GROUP > N) ? N - 1 : LO + OR_GROUP - 1;
    always_ff @(posedge clk) begin
      grp[g] <= |bits[HI:LO];
    end
  end

  // Second level: combinational OR of the group flags.
  assign any = |grp;

endmodule
